### rtl/dpg_pkg.sv
// Shared types, constants and codes for the detection position gate.
`default_nettype none

package dpg_pkg;

  // Coordinate format: signed Q12.4 pixels.
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 4;

  // Default number of history slots.
  localparam int HIST_DEPTH_DEF = 8;

  // Register field widths.
  localparam int JUMP_W   = 16;
  localparam int WARM_W   = 8;
  localparam int HLEN_W   = 4;
  localparam int FRAME_W  = 12;
  localparam int SCORE_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int RUN_W    = 8;
  localparam int STATUS_W = 3;

  // Operand width of the shared squaring multiplier.
  localparam int MUL_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_JUMP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_LEN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CONFIDENCE = 3'd5;

  // Register values after reset.
  localparam logic [JUMP_W-1:0]  RST_MAX_JUMP       = 16'd1600;
  localparam logic [WARM_W-1:0]  RST_WARMUP_COUNT   = 8'd3;
  localparam logic [HLEN_W-1:0]  RST_HISTORY_LEN    = 4'd5;
  localparam logic [FRAME_W-1:0] RST_FRAME_WIDTH    = 12'd640;
  localparam logic [FRAME_W-1:0] RST_FRAME_HEIGHT   = 12'd480;
  localparam logic [SCORE_W-1:0] RST_MIN_CONFIDENCE = 16'd19661;

  // Largest run count.
  localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

  // Item kinds.
  localparam logic KIND_CHECK = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 3'd0,
    STS_OUTSIDE  = 3'd1,
    STS_LOW_CONF = 3'd2,
    STS_JUMP     = 3'd3,
    STS_WARMUP   = 3'd4,
    STS_CLEARED  = 3'd5
  } status_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_LIM,
    ST_JUDGE,
    ST_RD_OLD,
    ST_COMMIT,
    ST_STATUS,
    ST_AVG,
    ST_DIV,
    ST_OUT
  } state_e;

  // Operand choice of the squaring multiplier.
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_DX,
    MUL_DY,
    MUL_LIM
  } mul_sel_e;

  // Input word.
  typedef struct packed {
    logic                         kind;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic [SCORE_W-1:0]           score;
  } in_item_t;

  // Result word.
  typedef struct packed {
    logic                         accepted;
    logic [STATUS_W-1:0]          status;
    logic signed [COORD_BITS-1:0] avg_x;
    logic signed [COORD_BITS-1:0] avg_y;
    logic signed [COORD_BITS-1:0] prev_x;
    logic signed [COORD_BITS-1:0] prev_y;
    logic [RUN_W-1:0]             run_count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_item;
    logic     clear_track;
    mul_sel_e mul_sel;
    logic     run_reset;
    logic     rd_old;
    logic     commit;
    logic     set_status;
    status_e  status_val;
    logic     div_start;
    logic     out_load;
  } dp_cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic kind;
    logic outside;
    logic low_conf;
    logic have_last;
    logic jump;
    logic warming;
    logic few_entries;
    logic div_done;
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/dpg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dpg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [ADDR_W-1:0]       waddr_i,
  input  wire logic [WIDTH-1:0]        wdata_i,
  input  wire logic                    re_i,
  input  wire logic [ADDR_W-1:0]       raddr_i,
  output logic [WIDTH-1:0]             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/dpg_div.sv
// Restoring divider, one quotient bit per cycle, for the history average.
`default_nettype none

module dpg_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quot_q, quot_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    rem_sh  = {rem_q, quot_q[NUM_W-1]};
    fits    = (rem_sh >= {1'b0, den_q});
    rem_sub = rem_sh - {1'b0, den_q};
  end

  // Iteration control.
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      quot_d = {quot_q[NUM_W-2:0], fits};
      rem_d  = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

### rtl/dpg_datapath.sv
// Datapath: registers, checks, squaring multiplier, history ring and averaging.
`default_nettype none

module dpg_datapath #(
  parameter int HIST_DEPTH = dpg_pkg::HIST_DEPTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  input  wire logic [dpg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [dpg_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire dpg_pkg::in_item_t                   in_data_i,
  input  wire dpg_pkg::dp_cmd_t                    cmd_i,
  output dpg_pkg::dp_sts_t                         sts_o,
  output dpg_pkg::out_item_t                       out_data_o
);

  localparam int CB     = dpg_pkg::COORD_BITS;
  localparam int FILL_W = $clog2(HIST_DEPTH + 1);
  localparam int IDX_W  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int SUM_W  = CB + FILL_W;
  localparam int ENT_W  = 2 * CB;
  localparam int MW     = dpg_pkg::MUL_W;

  // Configuration registers.
  logic [dpg_pkg::JUMP_W-1:0]  max_jump_q;
  logic [dpg_pkg::WARM_W-1:0]  warmup_q;
  logic [dpg_pkg::HLEN_W-1:0]  hist_len_q;
  logic [dpg_pkg::FRAME_W-1:0] frame_w_q;
  logic [dpg_pkg::FRAME_W-1:0] frame_h_q;
  logic [dpg_pkg::SCORE_W-1:0] min_conf_q;

  // Track state.
  dpg_pkg::in_item_t      item_q;
  logic signed [CB-1:0]   last_x_q, last_x_d;
  logic signed [CB-1:0]   last_y_q, last_y_d;
  logic                   have_last_q, have_last_d;
  logic [dpg_pkg::RUN_W-1:0] streak_q, streak_d;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic [IDX_W-1:0]       head_q, head_d;
  logic [SUM_W-1:0]       sum_x_q, sum_x_d;
  logic [SUM_W-1:0]       sum_y_q, sum_y_d;
  dpg_pkg::status_e       status_q, status_d;

  // Jump test.
  logic [2*MW:0]          acc_q;
  logic [2*MW-1:0]        lim_q;
  logic signed [CB:0]     dx, dy;
  logic [MW-1:0]          ux, uy;
  logic [MW-1:0]          mul_a;
  logic [2*MW-1:0]        prod;

  // History ring.
  logic [FILL_W-1:0]      limit;
  logic [FILL_W:0]        head_ext, fill_ext, old_ext;
  logic [IDX_W-1:0]       old_idx;
  logic                   drop;
  logic [ENT_W-1:0]       ring_rdata;
  logic [SUM_W-1:0]       old_x, old_y, new_x, new_y;

  // Averaging and result.
  logic                   x_done, y_done;
  logic [SUM_W-1:0]       quot_x, quot_y;
  logic                   few;
  dpg_pkg::out_item_t     out_q, out_d;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_jump_q <= dpg_pkg::RST_MAX_JUMP;
      warmup_q   <= dpg_pkg::RST_WARMUP_COUNT;
      hist_len_q <= dpg_pkg::RST_HISTORY_LEN;
      frame_w_q  <= dpg_pkg::RST_FRAME_WIDTH;
      frame_h_q  <= dpg_pkg::RST_FRAME_HEIGHT;
      min_conf_q <= dpg_pkg::RST_MIN_CONFIDENCE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dpg_pkg::CFG_MAX_JUMP:       max_jump_q <= cfg_data_i;
        dpg_pkg::CFG_WARMUP_COUNT:   warmup_q   <= cfg_data_i[dpg_pkg::WARM_W-1:0];
        dpg_pkg::CFG_HISTORY_LEN:    hist_len_q <= cfg_data_i[dpg_pkg::HLEN_W-1:0];
        dpg_pkg::CFG_FRAME_WIDTH:    frame_w_q  <= cfg_data_i[dpg_pkg::FRAME_W-1:0];
        dpg_pkg::CFG_FRAME_HEIGHT:   frame_h_q  <= cfg_data_i[dpg_pkg::FRAME_W-1:0];
        dpg_pkg::CFG_MIN_CONFIDENCE: min_conf_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input word capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
  end

  // Absolute distances to the last centre; both points are non-negative here.
  always_comb begin
    dx = (CB+1)'(item_q.pos_x) - (CB+1)'(last_x_q);
    dy = (CB+1)'(item_q.pos_y) - (CB+1)'(last_y_q);
    ux = dx[CB] ? MW'(-dx) : MW'(dx);
    uy = dy[CB] ? MW'(-dy) : MW'(dy);
  end

  // Shared squaring multiplier: dx, then dy, then the jump limit.
  always_comb begin
    case (cmd_i.mul_sel)
      dpg_pkg::MUL_DX:  mul_a = ux;
      dpg_pkg::MUL_DY:  mul_a = uy;
      dpg_pkg::MUL_LIM: mul_a = MW'(max_jump_q);
      default:          mul_a = '0;
    endcase
    prod = mul_a * mul_a;
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.mul_sel)
      dpg_pkg::MUL_DX:  acc_q <= {1'b0, prod};
      dpg_pkg::MUL_DY:  acc_q <= acc_q + {1'b0, prod};
      dpg_pkg::MUL_LIM: lim_q <= prod;
      default: ;
    endcase
  end

  // Effective history length, held between one and the ring depth.
  always_comb begin
    if (hist_len_q == '0) begin
      limit = FILL_W'(1);
    end else if (32'(hist_len_q) > HIST_DEPTH) begin
      limit = FILL_W'(HIST_DEPTH);
    end else begin
      limit = FILL_W'(hist_len_q);
    end
  end

  // Slot of the oldest entry and whether the next push drops it.
  always_comb begin
    head_ext = (FILL_W+1)'(head_q);
    fill_ext = {1'b0, fill_q};
    if (fill_ext > head_ext) begin
      old_ext = head_ext + (FILL_W+1)'(HIST_DEPTH) - fill_ext;
    end else begin
      old_ext = head_ext - fill_ext;
    end
    old_idx = old_ext[IDX_W-1:0];
    drop    = (fill_q >= limit);
  end

  // The ring keeps x in the low half and y in the high half of each entry.
  dpg_ram #(
    .WIDTH (ENT_W),
    .DEPTH (HIST_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (head_q),
    .wdata_i ({item_q.pos_y, item_q.pos_x}),
    .re_i    (cmd_i.rd_old),
    .raddr_i (old_idx),
    .rdata_o (ring_rdata)
  );

  // Accepted centres are non-negative, so they extend with zeros.
  always_comb begin
    old_x = drop ? SUM_W'(ring_rdata[CB-1:0]) : '0;
    old_y = drop ? SUM_W'(ring_rdata[ENT_W-1:CB]) : '0;
    new_x = SUM_W'(unsigned'(item_q.pos_x));
    new_y = SUM_W'(unsigned'(item_q.pos_y));
  end

  // Track state update.
  always_comb begin
    last_x_d    = last_x_q;
    last_y_d    = last_y_q;
    have_last_d = have_last_q;
    streak_d    = streak_q;
    fill_d      = fill_q;
    head_d      = head_q;
    sum_x_d     = sum_x_q;
    sum_y_d     = sum_y_q;
    status_d    = status_q;
    if (cmd_i.clear_track) begin
      last_x_d    = '0;
      last_y_d    = '0;
      have_last_d = 1'b0;
      streak_d    = '0;
      fill_d      = '0;
      head_d      = '0;
      sum_x_d     = '0;
      sum_y_d     = '0;
    end else if (cmd_i.run_reset) begin
      streak_d = '0;
    end else if (cmd_i.commit) begin
      last_x_d    = item_q.pos_x;
      last_y_d    = item_q.pos_y;
      have_last_d = 1'b1;
      if (streak_q != dpg_pkg::RUN_MAX) begin
        streak_d = streak_q + 1'b1;
      end
      if (!drop) begin
        fill_d = fill_q + 1'b1;
      end
      head_d  = (head_q == IDX_W'(HIST_DEPTH - 1)) ? '0 : head_q + 1'b1;
      sum_x_d = sum_x_q - old_x + new_x;
      sum_y_d = sum_y_q - old_y + new_y;
    end
    if (cmd_i.set_status) begin
      status_d = cmd_i.status_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q    <= '0;
      last_y_q    <= '0;
      have_last_q <= 1'b0;
      streak_q    <= '0;
      fill_q      <= '0;
      head_q      <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      status_q    <= dpg_pkg::STS_CLEARED;
    end else begin
      last_x_q    <= last_x_d;
      last_y_q    <= last_y_d;
      have_last_q <= have_last_d;
      streak_q    <= streak_d;
      fill_q      <= fill_d;
      head_q      <= head_d;
      sum_x_q     <= sum_x_d;
      sum_y_q     <= sum_y_d;
      status_q    <= status_d;
    end
  end

  // Serial dividers for the two running sums.
  dpg_div #(
    .NUM_W (SUM_W),
    .DEN_W (FILL_W)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (sum_x_q),
    .den_i   (fill_q),
    .done_o  (x_done),
    .quot_o  (quot_x)
  );

  dpg_div #(
    .NUM_W (SUM_W),
    .DEN_W (FILL_W)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (sum_y_q),
    .den_i   (fill_q),
    .done_o  (y_done),
    .quot_o  (quot_y)
  );

  // With fewer than two entries the average is the last centre.
  assign few = ({1'b0, fill_q} < (FILL_W+1)'(2));

  // Result register.
  always_comb begin
    out_d           = out_q;
    out_d.accepted  = (status_q == dpg_pkg::STS_OK);
    out_d.status    = status_q;
    out_d.avg_x     = few ? last_x_q : signed'(quot_x[CB-1:0]);
    out_d.avg_y     = few ? last_y_q : signed'(quot_y[CB-1:0]);
    out_d.prev_x    = last_x_q;
    out_d.prev_y    = last_y_q;
    out_d.run_count = streak_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // Flags for the controller.
  always_comb begin
    sts_o.kind        = (item_q.kind == dpg_pkg::KIND_CLEAR);
    sts_o.outside     = item_q.pos_x[CB-1] || item_q.pos_y[CB-1] ||
                        ((CB+1)'(unsigned'(item_q.pos_x)) >=
                         (CB+1)'({frame_w_q, {dpg_pkg::FRAC_BITS{1'b0}}})) ||
                        ((CB+1)'(unsigned'(item_q.pos_y)) >=
                         (CB+1)'({frame_h_q, {dpg_pkg::FRAC_BITS{1'b0}}}));
    sts_o.low_conf    = (item_q.score < min_conf_q);
    sts_o.have_last   = have_last_q;
    sts_o.jump        = (acc_q > {1'b0, lim_q});
    sts_o.warming     = (streak_q < warmup_q);
    sts_o.few_entries = few;
    sts_o.div_done    = x_done && y_done;
  end

  // The ring never holds more entries than it has slots.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, fill_q} <= (FILL_W+1)'(HIST_DEPTH))
    else $error("history fill count exceeds ring depth");

  // Without a last centre there is no history and no run.
  a_empty_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_last_q |-> (fill_q == '0) && (streak_q == '0))
    else $error("history or run count present without a last centre");

endmodule

`default_nettype wire

### rtl/dpg_ctrl.sv
// Controller: sequences one word through check, jump test, history update and average.
`default_nettype none

module dpg_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire dpg_pkg::dp_sts_t sts_i,
  output dpg_pkg::dp_cmd_t      cmd_o
);

  dpg_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  // The result register can take a new word when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dpg_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = dpg_pkg::ST_CHECK;
      end
      dpg_pkg::ST_CHECK: begin
        if (sts_i.kind) begin
          state_d = dpg_pkg::ST_OUT;
        end else if (sts_i.outside || sts_i.low_conf) begin
          state_d = dpg_pkg::ST_AVG;
        end else if (!sts_i.have_last) begin
          state_d = dpg_pkg::ST_RD_OLD;
        end else begin
          state_d = dpg_pkg::ST_SQ_X;
        end
      end
      dpg_pkg::ST_SQ_X:   state_d = dpg_pkg::ST_SQ_Y;
      dpg_pkg::ST_SQ_Y:   state_d = dpg_pkg::ST_SQ_LIM;
      dpg_pkg::ST_SQ_LIM: state_d = dpg_pkg::ST_JUDGE;
      dpg_pkg::ST_JUDGE: begin
        state_d = sts_i.jump ? dpg_pkg::ST_AVG : dpg_pkg::ST_RD_OLD;
      end
      dpg_pkg::ST_RD_OLD: state_d = dpg_pkg::ST_COMMIT;
      dpg_pkg::ST_COMMIT: state_d = dpg_pkg::ST_STATUS;
      dpg_pkg::ST_STATUS: state_d = dpg_pkg::ST_AVG;
      dpg_pkg::ST_AVG: begin
        state_d = sts_i.few_entries ? dpg_pkg::ST_OUT : dpg_pkg::ST_DIV;
      end
      dpg_pkg::ST_DIV: begin
        if (sts_i.div_done) state_d = dpg_pkg::ST_OUT;
      end
      dpg_pkg::ST_OUT: begin
        if (out_free) state_d = dpg_pkg::ST_IDLE;
      end
      default: state_d = dpg_pkg::ST_IDLE;
    endcase
  end

  // Commands for the current state.
  always_comb begin
    cmd_o            = '0;
    cmd_o.mul_sel    = dpg_pkg::MUL_NONE;
    cmd_o.status_val = dpg_pkg::STS_OK;
    in_ready_o       = 1'b0;
    case (state_q)
      dpg_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      dpg_pkg::ST_CHECK: begin
        if (sts_i.kind) begin
          cmd_o.clear_track = 1'b1;
          cmd_o.set_status  = 1'b1;
          cmd_o.status_val  = dpg_pkg::STS_CLEARED;
        end else if (sts_i.outside) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status_val = dpg_pkg::STS_OUTSIDE;
        end else if (sts_i.low_conf) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status_val = dpg_pkg::STS_LOW_CONF;
        end
      end
      dpg_pkg::ST_SQ_X:   cmd_o.mul_sel = dpg_pkg::MUL_DX;
      dpg_pkg::ST_SQ_Y:   cmd_o.mul_sel = dpg_pkg::MUL_DY;
      dpg_pkg::ST_SQ_LIM: cmd_o.mul_sel = dpg_pkg::MUL_LIM;
      dpg_pkg::ST_JUDGE: begin
        if (sts_i.jump) begin
          cmd_o.run_reset  = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status_val = dpg_pkg::STS_JUMP;
        end
      end
      dpg_pkg::ST_RD_OLD: cmd_o.rd_old = 1'b1;
      dpg_pkg::ST_COMMIT: cmd_o.commit = 1'b1;
      dpg_pkg::ST_STATUS: begin
        cmd_o.set_status = 1'b1;
        cmd_o.status_val = sts_i.warming ? dpg_pkg::STS_WARMUP : dpg_pkg::STS_OK;
      end
      dpg_pkg::ST_AVG: cmd_o.div_start = !sts_i.few_entries;
      dpg_pkg::ST_DIV: ;
      dpg_pkg::ST_OUT: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  // Result valid flag: set on load, cleared when the word is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dpg_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register loaded while a word is still waiting");

  // Only one word is in work at a time.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a word is still in work");

endmodule

`default_nettype wire

### rtl/detection_position_gate.sv
// Top level of the detection position gate: controller, datapath and port wiring.
//
// Usage: each input word on in_data_i is either a detection (centre x, y in
// signed Q12.4 pixels and a Q0.16 score) or a clear command. For every input
// word exactly one result word appears on out_data_o: status, accepted flag,
// history average, last accepted centre and run count.
// Channels: in_valid_i/in_ready_o and out_valid_o/out_ready_i are valid/ready
// pairs; a word moves when both are high. Registers are written on the
// cfg_valid_i/cfg_ready_o channel (cfg_ready_o is always high) with the
// register number on cfg_index_i; write them only while the block is idle.
// Flow: a clear goes from the check straight to the result. A detection passes
// the check and, where it needs them, the jump test and the history update;
// when at least two centres are held, bit-serial dividers then form the average
// one quotient bit per step over sums of SUM_W = 16 + clog2(HIST_DEPTH + 1) bits.
// Only one word is in work at a time; the next word is taken once the previous
// result sits in the output register, even if it is not yet taken.
// Reset: registers return to their defaults, the track and history empty.
// Stall: a result waits in the output register while out_ready_i is low; a
// following result waits in the controller until that register is free.
`default_nettype none

module detection_position_gate #(
  parameter int HIST_DEPTH = dpg_pkg::HIST_DEPTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [dpg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [dpg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire dpg_pkg::in_item_t              in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output dpg_pkg::out_item_t                  out_data_o
);

  dpg_pkg::dp_cmd_t cmd;
  dpg_pkg::dp_sts_t sts;

  // Register writes never stall.
  assign cfg_ready_o = 1'b1;

  dpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dpg_datapath #(
    .HIST_DEPTH (HIST_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
